// ===== rtl/srm_pkg.sv =====
`timescale 1ns / 1ps

package srm_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int WORD_WIDTH    = 32;
   localparam int POS_WIDTH     = 8;
   localparam int OP_WIDTH      = 2;
   localparam int REQ_DATA_WIDTH = 64;
   localparam int RSP_DATA_WIDTH = 32;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_MERGE = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

endpackage

// ===== rtl/srm_ram.sv =====
`timescale 1ns / 1ps

module srm_ram import srm_pkg::*; #(
   parameter int WIDTH = WORD_WIDTH,
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/sorted_run_merge_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit first)                              tuser
// req_      in         position, write_value, range_low, range_mid,       opcode
//                      range_high (64 bits)
// rsp_      out        read_value (32 bits)                               range_error
//
// Write, no-op and rejected merge pass S_FINISH to the result register; a read first passes S_READ.
// A merge of n = range_high - range_low + 1 words runs S_COPY, S_DRAIN, S_PRIME and S_MERGE: one pass
// copies the runs through array read port a into scratch, one pass writes
// one merged word per cycle back into the array.
// Reset is synchronous and clears control only; the memories need no clearing pass.
// One request is worked on at a time; a result stalled on rsp_ holds only the next.

module sorted_run_merge_core import srm_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // position, write_value, range_low, range_mid, range_high
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // opcode
   input  logic [OP_WIDTH-1:0]       req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // read_value
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // range_error
   output logic                      rsp_tuser
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [16:0] DEPTH_W = 17'(DEPTH);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_READ   = 7'b0000010,
      S_COPY   = 7'b0000100,
      S_DRAIN  = 7'b0001000,
      S_PRIME  = 7'b0010000,
      S_MERGE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [POS_WIDTH-1:0]  req_position;
   logic [WORD_WIDTH-1:0] req_write_value;
   logic [POS_WIDTH-1:0]  req_range_low;
   logic [POS_WIDTH-1:0]  req_range_mid;
   logic [POS_WIDTH-1:0]  req_range_high;
   opcode_type            req_opcode;

   assign req_position    = req_tdata[7:0];
   assign req_write_value = req_tdata[39:8];
   assign req_range_low   = req_tdata[47:40];
   assign req_range_mid   = req_tdata[55:48];
   assign req_range_high  = req_tdata[63:56];
   assign req_opcode      = opcode_type'(req_tuser);

   logic [POS_WIDTH-1:0]  idx_ff, idx_in;
   logic [POS_WIDTH:0]    i_ff, i_in;
   logic [POS_WIDTH:0]    j_ff, j_in;
   logic [POS_WIDTH-1:0]  lo_ff, lo_in;
   logic [POS_WIDTH-1:0]  mid_ff, mid_in;
   logic [POS_WIDTH-1:0]  hi_ff, hi_in;
   logic                  cp_wr_ff, cp_wr_in;
   logic [AW-1:0]         cp_addr_ff, cp_addr_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [WORD_WIDTH-1:0] res_value_ff, res_value_in;
   logic                  res_err_ff, res_err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  arr_we;
   logic [AW-1:0]         arr_waddr;
   logic [WORD_WIDTH-1:0] arr_wdata;
   logic [WORD_WIDTH-1:0] arr_rdata_a;
   logic [WORD_WIDTH-1:0] arr_rdata_b;
   logic [AW-1:0]         scr_raddr_a;
   logic [AW-1:0]         scr_raddr_b;
   logic [WORD_WIDTH-1:0] scr_rdata_a;
   logic [WORD_WIDTH-1:0] scr_rdata_b;

   logic                  req_fire;
   logic                  pos_ok;
   logic                  range_ok;
   logic                  left_done;
   logic                  right_done;
   logic                  take_left;
   logic [POS_WIDTH:0]    i_next;
   logic [POS_WIDTH:0]    j_next;
   logic [POS_WIDTH:0]    mid_plus;
   logic                  rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign pos_ok     = (17'(req_position) < DEPTH_W);
   assign range_ok   = (req_range_low <= req_range_mid) && (req_range_mid <= req_range_high)
                       && (17'(req_range_high) < DEPTH_W);

   assign left_done  = (i_ff > {1'b0, mid_ff});
   assign right_done = (j_ff > {1'b0, hi_ff});
   assign take_left  = !left_done
                       && (right_done || ($signed(scr_rdata_a) <= $signed(scr_rdata_b)));
   assign i_next     = take_left ? (i_ff + 1'b1) : i_ff;
   assign j_next     = take_left ? j_ff : (j_ff + 1'b1);
   assign mid_plus   = {1'b0, mid_ff} + 1'b1;
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      cp_wr_in     = 1'b0;
      cp_addr_in   = cp_addr_ff;
      rd_ok_in     = rd_ok_ff;
      res_value_in = res_value_ff;
      res_err_in   = res_err_ff;
      arr_we       = 1'b0;
      arr_waddr    = AW'(idx_ff);
      arr_wdata    = take_left ? scr_rdata_a : scr_rdata_b;
      scr_raddr_a  = AW'(i_next[POS_WIDTH-1:0]);
      scr_raddr_b  = AW'(j_next[POS_WIDTH-1:0]);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_value_in = '0;
               res_err_in   = 1'b0;
               rd_ok_in     = pos_ok;
               lo_in        = req_range_low;
               mid_in       = req_range_mid;
               hi_in        = req_range_high;
               idx_in       = req_range_low;
               case (req_opcode)
                  OP_WRITE: begin
                     arr_we    = pos_ok;
                     arr_waddr = AW'(req_position);
                     arr_wdata = req_write_value;
                     state_in  = S_FINISH;
                  end
                  OP_READ: begin
                     state_in = S_READ;
                  end
                  OP_MERGE: begin
                     res_err_in = !range_ok;
                     state_in   = range_ok ? S_COPY : S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_READ: begin
            res_value_in = rd_ok_ff ? arr_rdata_b : '0;
            state_in     = S_FINISH;
         end
         S_COPY: begin
            cp_wr_in   = 1'b1;
            cp_addr_in = AW'(idx_ff);
            if (idx_ff == hi_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_PRIME;
         end
         S_PRIME: begin
            scr_raddr_a = AW'(lo_ff);
            scr_raddr_b = AW'(mid_plus[POS_WIDTH-1:0]);
            i_in        = {1'b0, lo_ff};
            j_in        = mid_plus;
            idx_in      = lo_ff;
            state_in    = S_MERGE;
         end
         S_MERGE: begin
            arr_we = 1'b1;
            i_in   = i_next;
            j_in   = j_next;
            if (idx_ff == hi_ff) begin
               state_in = S_FINISH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_value_ff;
         rsp_err_in   = res_err_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cp_wr_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cp_wr_ff     <= cp_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      cp_addr_ff   <= cp_addr_in;
      rd_ok_ff     <= rd_ok_in;
      res_value_ff <= res_value_in;
      res_err_ff   <= res_err_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_err_ff   <= rsp_err_in;
   end

   srm_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_array_ram (
      .clock     (clock),
      .wr_en     (arr_we),
      .wr_addr   (arr_waddr),
      .wr_data   (arr_wdata),
      .rd_addr_a (AW'(idx_ff)),
      .rd_data_a (arr_rdata_a),
      .rd_addr_b (AW'(req_position)),
      .rd_data_b (arr_rdata_b)
   );

   srm_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_scratch_ram (
      .clock     (clock),
      .wr_en     (cp_wr_ff),
      .wr_addr   (cp_addr_ff),
      .wr_data   (arr_rdata_a),
      .rd_addr_a (scr_raddr_a),
      .rd_data_a (scr_rdata_a),
      .rd_addr_b (scr_raddr_b),
      .rd_data_b (scr_rdata_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== rtl/srm_checker.sv =====
`timescale 1ns / 1ps

module srm_checker import srm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input logic [OP_WIDTH-1:0]       req_tuser,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                      rsp_tuser
);

   logic req_word;

   assign req_word = req_tvalid && req_tready;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected merge returned a nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      req_word |=> !req_tready)
      else $error("second request taken while one is in work");

   assert property (@(posedge clock) disable iff (reset)
      req_word && !rsp_tvalid && (req_tuser == OP_WRITE || req_tuser == OP_NOP)
      |-> ##2 rsp_tvalid && rsp_tdata == '0 && !rsp_tuser)
      else $error("write or no-op result missing or wrong");

endmodule

bind sorted_run_merge_core srm_checker u_srm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_sorted_run_merge_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_run_merge_core;
   import srm_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int ITEM_COUNT   = 1170;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 600;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      opcode_type  op;
      logic [7:0]  pos;
      logic [31:0] val;
      logic [7:0]  lo;
      logic [7:0]  mid;
      logic [7:0]  hi;
      logic        typed;
      logic [31:0] exp_val;
      logic        exp_err;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        range_error;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // position, write_value, range_low, range_mid, range_high
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   // opcode
   logic [OP_WIDTH-1:0]       req_tuser = OP_NOP;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // read_value
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   // range_error
   logic                      rsp_tuser;

   sorted_run_merge_core #(.DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_word_type    request_plan [$];
   result_word_type pending_results [$];
   logic [31:0]     shadow_store   [0:DEPTH-1];
   logic [31:0]     shadow_scratch [0:DEPTH-1];

   int req_count = 0;
   int rsp_count = 0;
   int errors    = 0;

   function automatic result_word_type merge_store_step(input opcode_type op,
                                                        input logic [7:0] pos,
                                                        input logic [31:0] wval,
                                                        input logic [7:0] lo,
                                                        input logic [7:0] mid,
                                                        input logic [7:0] hi);
      result_word_type res;
      int i;
      int j;
      int k;
      res = '0;
      case (op)
         OP_WRITE: begin
            shadow_store[pos] = wval;
         end
         OP_READ: begin
            res.read_value = shadow_store[pos];
         end
         OP_MERGE: begin
            if (lo > mid || mid > hi || int'(hi) >= DEPTH) begin
               res.range_error = 1'b1;
            end else begin
               for (i = int'(lo); i <= int'(hi); i++) shadow_scratch[i] = shadow_store[i];
               i = int'(lo);
               j = int'(mid) + 1;
               k = int'(lo);
               while (i <= int'(mid) && j <= int'(hi)) begin
                  if ($signed(shadow_scratch[i]) <= $signed(shadow_scratch[j])) begin
                     shadow_store[k] = shadow_scratch[i];
                     i++;
                  end else begin
                     shadow_store[k] = shadow_scratch[j];
                     j++;
                  end
                  k++;
               end
               while (i <= int'(mid)) begin
                  shadow_store[k] = shadow_scratch[i];
                  i++;
                  k++;
               end
               while (j <= int'(hi)) begin
                  shadow_store[k] = shadow_scratch[j];
                  j++;
                  k++;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic plan_item(input opcode_type op, input logic [7:0] pos, input logic [31:0] val,
                            input logic [7:0] lo, input logic [7:0] mid, input logic [7:0] hi);
      req_word_type w;
      w = '{op, pos, val, lo, mid, hi, 1'b0, 32'h0, 1'b0};
      request_plan.push_back(w);
   endtask

   // Writes an ascending run, with repeats, to positions first..last.
   task automatic plan_sorted_run(input int first, input int last);
      longint v;
      int step;
      int p;
      case ($urandom_range(0, 3))
         0: step = 3;
         1: step = 1000;
         2: step = 1 << 24;
         default: step = 0;
      endcase
      if ($urandom_range(0, 4) == 0) v = -64'sd2147483648;
      else v = longint'($signed($urandom));
      for (p = first; p <= last; p++) begin
         plan_item(OP_WRITE, 8'(p), v[31:0], 8'($urandom), 8'($urandom), 8'($urandom));
         v = v + longint'($urandom_range(0, step));
         if (v > 64'sd2147483647) v = 64'sd2147483647;
      end
   endtask

   task automatic plan_merge_sequence(input int lo, input int mid, input int hi);
      int r;
      plan_sorted_run(lo, mid);
      if (mid < hi) plan_sorted_run(mid + 1, hi);
      plan_item(OP_MERGE, 8'($urandom), $urandom, 8'(lo), 8'(mid), 8'(hi));
      for (r = $urandom_range(1, 3); r > 0; r--) begin
         plan_item(OP_READ, 8'(lo + $urandom_range(0, hi - lo)), $urandom,
                   8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      bit offer;
      int send_idx;
      int burst_left;
      int gap_left;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idx = 0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) send_idx++;
         if (!(req_tvalid && !req_tready)) begin
            if (send_idx < request_plan.size()) begin
               if (burst_left > 0) begin
                  offer = 1'b1;
                  burst_left--;
               end else if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(0, 12);
                  gap_left = $urandom_range(1, 8);
                  offer = 1'b1;
               end
            end
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= {request_plan[send_idx].hi, request_plan[send_idx].mid,
                             request_plan[send_idx].lo, request_plan[send_idx].val,
                             request_plan[send_idx].pos};
               req_tuser <= request_plan[send_idx].op;
            end
         end
      end
   end

   always @(posedge clock) begin
      int pattern_cycle;
      int stall_mode;
      int hold_cycles;
      bit hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         pattern_cycle = 0;
         stall_mode = 0;
         hold_cycles = 0;
         hold_done = 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_cycles++;
         if (hold_cycles >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
         pattern_cycle++;
         if (pattern_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= (pattern_cycle % 4) != 3;
            2: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= (pattern_cycle % 16) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      result_word_type predicted;
      result_word_type oldest;
      req_word_type src;
      if (!reset && req_tvalid && req_tready) begin
         predicted = merge_store_step(opcode_type'(req_tuser), req_tdata[7:0],
                                      req_tdata[39:8], req_tdata[47:40],
                                      req_tdata[55:48], req_tdata[63:56]);
         src = request_plan[req_count];
         if (src.typed) pending_results.push_back({src.exp_val, src.exp_err});
         else pending_results.push_back(predicted);
         req_count++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing pending, expected none, actual %h %b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata !== oldest.read_value) begin
               $display("%0t: read_value expected %h, actual %h",
                        $time, oldest.read_value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== oldest.range_error) begin
               $display("%0t: range_error expected %b, actual %b",
                        $time, oldest.range_error, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("sorted_run_merge_core test failed");
      $finish;
   end

   initial begin
      req_word_type directed_tbl [0:24];
      int pick;
      int n;
      int lo;
      int mid;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      directed_tbl = '{
         '{OP_WRITE, 8'h00, 32'h8000_0000, 8'hff, 8'hff, 8'hff, 1'b0, 32'h0, 1'b0},
         '{OP_WRITE, 8'hff, 32'h7fff_ffff, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_READ,  8'h00, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 1'b1, 32'h8000_0000, 1'b0},
         '{OP_READ,  8'hff, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b1, 32'h7fff_ffff, 1'b0},
         '{OP_WRITE, 8'h01, 32'hffff_ffff, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_WRITE, 8'h02, 32'h0000_0000, 8'hff, 8'hff, 8'hff, 1'b0, 32'h0, 1'b0},
         '{OP_NOP,   8'hff, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 1'b1, 32'h0, 1'b0},
         '{OP_NOP,   8'h00, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b1, 32'h0, 1'b0},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h03, 8'h02, 8'h05, 1'b1, 32'h0, 1'b1},
         '{OP_MERGE, 8'hff, 32'hffff_ffff, 8'h01, 8'h02, 8'h01, 1'b1, 32'h0, 1'b1},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'hff, 8'h00, 8'hff, 1'b1, 32'h0, 1'b1},
         '{OP_MERGE, 8'hff, 32'hffff_ffff, 8'h00, 8'hff, 8'h00, 1'b1, 32'h0, 1'b1},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b1, 32'h0, 1'b0},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h01, 8'h02, 8'h02, 1'b1, 32'h0, 1'b0},
         '{OP_WRITE, 8'h03, 32'h0000_0005, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_WRITE, 8'h04, 32'hffff_fff9, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h03, 8'h03, 8'h04, 1'b1, 32'h0, 1'b0},
         '{OP_READ,  8'h03, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_READ,  8'h04, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_WRITE, 8'h05, 32'h0000_0003, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_WRITE, 8'h06, 32'h0000_0003, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h05, 8'h05, 8'h06, 1'b1, 32'h0, 1'b0},
         '{OP_READ,  8'h05, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0},
         '{OP_MERGE, 8'h00, 32'h0000_0000, 8'h00, 8'h02, 8'h06, 1'b0, 32'h0, 1'b0},
         '{OP_READ,  8'h06, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 1'b0, 32'h0, 1'b0}
      };
      foreach (directed_tbl[r]) request_plan.push_back(directed_tbl[r]);

      // A full-depth merge first, so that every entry holds a written word from then on.
      plan_merge_sequence(0, DEPTH / 2 - 1, DEPTH - 1);
      while (request_plan.size() < ITEM_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            n = ($urandom_range(0, 32) == 0) ? $urandom_range(17, DEPTH) : $urandom_range(1, 16);
            lo = $urandom_range(0, DEPTH - n);
            mid = lo + $urandom_range(0, n - 1);
            plan_merge_sequence(lo, mid, lo + n - 1);
         end else if (pick < 65) begin
            n = $urandom_range(1, 24);
            lo = $urandom_range(0, DEPTH - n);
            mid = lo + $urandom_range(0, n - 1);
            plan_item(OP_MERGE, 8'($urandom), $urandom, 8'(lo), 8'(mid), 8'(lo + n - 1));
         end else if (pick < 75) begin
            do begin
               a = 8'($urandom);
               b = 8'($urandom);
               c = 8'($urandom);
            end while (a <= b && b <= c);
            plan_item(OP_MERGE, 8'($urandom), $urandom, a, b, c);
         end else if (pick < 85) begin
            plan_item(OP_READ, 8'($urandom), $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 95) begin
            plan_item(OP_WRITE, 8'($urandom), $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            plan_item(OP_NOP, 8'($urandom), $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (req_count < request_plan.size() || pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("sorted_run_merge_core test passed");
      end else begin
         $display("sorted_run_merge_core test failed");
      end
      $finish;
   end

endmodule
